[hdl/qdpr_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qdpr_pkg
// Shared types and constants for the quantized dot product requantizer.
// ----------------------------------------------------------------------------
package qdpr_pkg;

   // configuration address width and register index
   localparam int CSR_ADDR_W = 3;
   localparam logic REG_REQUANT_SHIFT = 1'b0;

   // requantization constants
   localparam logic signed [63:0] RND_NUDGE = 64'sh0000_0000_4000_0000;
   localparam logic [63:0] MIN_SQUARED = 64'h4000_0000_0000_0000;
   localparam logic [31:0] Q31_MAX = 32'h7fff_ffff;
   localparam logic signed [32:0] SAT_MAX = 33'sd127;
   localparam logic signed [32:0] SAT_MIN = -33'sd128;

   // controller states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MUL,
      ST_RND,
      ST_SHF
   } state_type;

   // datapath commands
   typedef struct packed {
      logic acc_en;
      logic mult_load;
      logic mul_en;
      logic acc_clr;
      logic rnd_en;
      logic out_load;
   } cmd_type;

endpackage : qdpr_pkg
`default_nettype wire

[hdl/qdpr_csr.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qdpr_csr
// Configuration register file holding the shared requantization shift.
// ----------------------------------------------------------------------------
module qdpr_csr
   import qdpr_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [31:0]           csr_pwdata,
   output logic      [31:0]           csr_prdata,
   output logic                       csr_pready,
   output logic signed [5:0]          requant_shift
);

   logic signed [5:0] shift_ff;
   logic signed [5:0] shift_in;
   logic              wr_hit;

   // write decode, index taken from the word address
   assign wr_hit = csr_psel && csr_penable && csr_pwrite &&
                   (csr_paddr[2] == REG_REQUANT_SHIFT);

   always_comb begin
      shift_in = shift_ff;
      if (wr_hit) begin
         shift_in = csr_pwdata[5:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         shift_ff <= '0;
      end else begin
         shift_ff <= shift_in;
      end
   end

   // read back, sign extended
   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[2] == REG_REQUANT_SHIFT) begin
         csr_prdata = {{26{shift_ff[5]}}, shift_ff};
      end
   end

   assign csr_pready    = 1'b1;
   assign requant_shift = shift_ff;

endmodule : qdpr_csr
`default_nettype wire

[hdl/qdpr_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qdpr_ctrl
// Sequencer for accumulate, multiply, round and shift steps plus output valid.
// ----------------------------------------------------------------------------
module qdpr_ctrl
   import qdpr_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   input  wire logic req_last_term,
   output logic      req_stall,
   output logic      rsp_valid,
   input  wire logic rsp_stall,
   output cmd_type   cmd,
   output state_type state
);

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   logic      req_take;

   assign req_take = req_valid && (state_ff == ST_IDLE);

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               cmd.acc_en = 1'b1;
               if (req_last_term) begin
                  cmd.mult_load = 1'b1;
                  state_in      = ST_MUL;
               end
            end
         end
         ST_MUL: begin
            cmd.mul_en  = 1'b1;
            cmd.acc_clr = 1'b1;
            state_in    = ST_RND;
         end
         ST_RND: begin
            cmd.rnd_en = 1'b1;
            state_in   = ST_SHF;
         end
         ST_SHF: begin
            // wait until the output register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // output valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign state     = state_ff;

endmodule : qdpr_ctrl
`default_nettype wire

[hdl/qdpr_dp.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qdpr_dp
// Datapath: multiply-accumulate, doubling high multiply, shift and saturate.
// ----------------------------------------------------------------------------
module qdpr_dp
   import qdpr_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire cmd_type            cmd,
   input  wire logic        [7:0]  activation,
   input  wire logic signed [7:0]  weight,
   input  wire logic signed [31:0] channel_multiplier,
   input  wire logic signed [5:0]  requant_shift,
   output logic signed      [7:0]  out_value
);

   logic        [31:0] acc_ff;
   logic        [31:0] acc_in;
   logic signed [31:0] mult_ff;
   logic signed [63:0] prod_ff;
   logic signed [31:0] stage_ff;
   logic signed [31:0] stage_in;
   logic signed [7:0]  out_ff;
   logic signed [7:0]  out_in;

   logic signed [16:0] term;
   logic signed [63:0] nudged;

   logic        [5:0]  left_amt;
   logic        [4:0]  right_amt;
   logic        [31:0] left_val;
   logic signed [31:0] floor_val;
   logic        [31:0] rem_mask;
   logic        [31:0] rem_bits;
   logic        [31:0] rem_thr;
   logic               round_up;
   logic signed [32:0] shifted;

   // product of unsigned activation and signed weight
   assign term = $signed({1'b0, activation}) * weight;

   // wrapping accumulator
   always_comb begin
      acc_in = acc_ff;
      if (cmd.acc_clr) begin
         acc_in = '0;
      end else if (cmd.acc_en) begin
         acc_in = acc_ff + {{15{term[16]}}, term};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
      end else begin
         acc_ff <= acc_in;
      end
   end

   // multiplier capture and full product
   always_ff @(posedge clock) begin
      if (cmd.mult_load) begin
         mult_ff <= channel_multiplier;
      end
      if (cmd.mul_en) begin
         prod_ff <= $signed(acc_ff) * mult_ff;
      end
   end

   // rounding doubling high part; the product is 2^62 only when both are minimum
   always_comb begin
      nudged   = prod_ff + (prod_ff[63] ? -RND_NUDGE : RND_NUDGE);
      stage_in = nudged[62:31];
      if (prod_ff == MIN_SQUARED) begin
         stage_in = Q31_MAX;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rnd_en) begin
         stage_ff <= stage_in;
      end
   end

   // shared shift: rounding right shift or wrapping left shift
   always_comb begin
      left_amt  = 6'(-requant_shift);
      right_amt = requant_shift[4:0];
      left_val  = left_amt[5] ? '0 : (stage_ff << left_amt[4:0]);
      floor_val = stage_ff >>> right_amt;
      rem_mask  = (32'h1 << right_amt) - 32'h1;
      rem_bits  = stage_ff & rem_mask;
      rem_thr   = (rem_mask >> 1) + {31'b0, stage_ff[31]};
      round_up  = (rem_bits > rem_thr);
      if (requant_shift[5] || (requant_shift == 6'sd0)) begin
         shifted = {left_val[31], left_val};
      end else begin
         shifted = {floor_val[31], floor_val} + {32'b0, round_up};
      end
   end

   // saturate to int8
   always_comb begin
      if (shifted > SAT_MAX) begin
         out_in = SAT_MAX[7:0];
      end else if (shifted < SAT_MIN) begin
         out_in = SAT_MIN[7:0];
      end else begin
         out_in = shifted[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         out_ff <= out_in;
      end
   end

   assign out_value = out_ff;

endmodule : qdpr_dp
`default_nettype wire

[hdl/quantized_dot_product_requantizer.sv]
`timescale 1ns / 1ps
`default_nettype none
// A last term is taken through the multiply, round and shift/saturate steps
// of the sequencer before its result is loaded into the output register.
// Throughput: one term per cycle while the sequencer is idle; a last term stalls
// further terms until its result is loaded, which waits while the output register is still held by a stalled result.
// Reset: synchronous active high; clears the accumulator, shift register,
// sequencer state and output valid.
// ----------------------------------------------------------------------------
// quantized_dot_product_requantizer
// Dot product of uint8 activations and int8 weights, requantized to a saturated int8 result.
// ----------------------------------------------------------------------------
module quantized_dot_product_requantizer
   import qdpr_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic        [7:0]     req_activation,
   input  wire logic signed [7:0]     req_weight,
   input  wire logic signed [31:0]    req_channel_multiplier,
   input  wire logic                  req_last_term,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic signed      [7:0]     rsp_out_value,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [31:0]           csr_pwdata,
   output logic      [31:0]           csr_prdata,
   output logic                       csr_pready
);

   cmd_type           cmd;
   state_type         state;
   logic signed [5:0] requant_shift;

   // configuration registers
   qdpr_csr u_csr (
      .clock         (clock),
      .reset         (reset),
      .csr_psel      (csr_psel),
      .csr_penable   (csr_penable),
      .csr_pwrite    (csr_pwrite),
      .csr_paddr     (csr_paddr),
      .csr_pwdata    (csr_pwdata),
      .csr_prdata    (csr_prdata),
      .csr_pready    (csr_pready),
      .requant_shift (requant_shift)
   );

   // sequencer
   qdpr_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_last_term (req_last_term),
      .req_stall     (req_stall),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .cmd           (cmd),
      .state         (state)
   );

   // arithmetic
   qdpr_dp u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .activation         (req_activation),
      .weight             (req_weight),
      .channel_multiplier (req_channel_multiplier),
      .requant_shift      (requant_shift),
      .out_value          (rsp_out_value)
   );

   // a last term blocks further items on the next cycle
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_last_term) |=> req_stall)
      else $error("item accepted during requantization");

   // the result reaches the output stage after the multiply and round steps of a last term
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_last_term) |-> ##3
      (rsp_valid || state == ST_SHF))
      else $error("result missing after last term");

   // a new result only comes out of the shift step
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state == ST_SHF))
      else $error("result without requantization");

   // multiply step always clears the accumulator
   assert property (@(posedge clock) disable iff (reset)
      (state == ST_MUL) |-> (cmd.mul_en && cmd.acc_clr && !cmd.acc_en))
      else $error("accumulator not cleared with multiply");

endmodule : quantized_dot_product_requantizer
`default_nettype wire
